@@ sv/first_fit_heap_allocator_macros.svh @@
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_macros.svh
// Assertion macros shared by the allocator modules. They expect signals
// named aclk and aresetn in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ffha_pkg.sv @@
// ---------------------------------------------------------------------------
// ffha_pkg
// Payload types, datapath command codes and control/status structs for the
// first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

    // Field widths and granule geometry
    localparam int OFFSET_W      = 15;
    localparam int GRANULE_BYTES = 8;
    localparam int GRANULE_SHIFT = $clog2(GRANULE_BYTES);
    localparam int UNIT_W        = OFFSET_W - GRANULE_SHIFT;
    localparam int WANT_W        = UNIT_W + 1;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Read address select
    localparam logic [1:0] RD_ZERO   = 2'd0;
    localparam logic [1:0] RD_FOLLOW = 2'd1;
    localparam logic [1:0] RD_UNIT   = 2'd2;

    // Current header register update
    localparam logic [2:0] CUR_HOLD  = 3'd0;
    localparam logic [2:0] CUR_START = 3'd1;
    localparam logic [2:0] CUR_LOAD  = 3'd2;
    localparam logic [2:0] CUR_STEP  = 3'd3;
    localparam logic [2:0] CUR_ADV   = 3'd4;
    localparam logic [2:0] CUR_MERGE = 3'd5;

    // Block store write select
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_MERGE = 3'd1;
    localparam logic [2:0] WR_ALLOC = 3'd2;
    localparam logic [2:0] WR_SPLIT = 3'd3;
    localparam logic [2:0] WR_FREE  = 3'd4;

    typedef struct packed {
        logic                operation;
        logic [OFFSET_W-1:0] request_bytes;
        logic [OFFSET_W-1:0] payload_offset;
    } ffha_in_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] result_offset;
        logic                success;
    } ffha_out_t;

    // Controller to datapath
    typedef struct packed {
        logic       take_in;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [2:0] upd;
        logic [2:0] wr;
        logic       out_load;
        logic       out_ok;
    } ffha_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_op;
        logic in_free_ok;
        logic cur_used;
        logic nxt_in;
        logic fits;
        logic need_split;
        logic rd_used;
        logic out_free;
    } ffha_sts_t;

endpackage

@@ sv/ffha_datapath.sv @@
// ---------------------------------------------------------------------------
// ffha_datapath
// Block store, current header registers, walk arithmetic and the result
// register. Acts only on commands from the controller.
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"

module ffha_datapath import ffha_pkg::*; #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ffha_in_t  s_payload,
    input  ffha_cmd_t cmd,
    output ffha_sts_t sts,
    output logic      m_valid,
    input  logic      m_ready,
    output ffha_out_t m_payload
);

    localparam int IDX_W  = $clog2(HEAP_UNITS);
    localparam int LEN_W  = IDX_W;
    localparam int ENT_W  = LEN_W + 1;
    localparam int CMP_W  = (LEN_W > WANT_W) ? LEN_W : WANT_W;
    localparam int WIDE_W = CMP_W + 2;
    localparam int RO_W   = WIDE_W + OFFSET_W;

    // Block store: bit 0 used mark, upper bits payload length in granules
    logic [ENT_W-1:0] mem [HEAP_UNITS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             ovr_reg, ovr_next;
    logic             hdr0_valid_reg;

    logic             op_reg;
    logic [WANT_W-1:0] want_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [LEN_W-1:0] cur_len_reg;
    logic             cur_used_reg;

    logic             m_valid_reg;
    ffha_out_t        m_payload_reg, m_payload_next;

    logic [LEN_W-1:0]  rd_len;
    logic              rd_used;
    logic [WIDE_W-1:0] follow_w, merged_w, split_idx_w, split_len_w, in_unit_m1;
    logic [UNIT_W-1:0] in_unit;
    logic [WANT_W-1:0] in_want;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              wr_en;
    logic [RO_W-1:0]   ro_w;
    logic              out_free;

    // Header 0 reads as the whole-heap free block until first written
    assign rd_len  = ovr_reg ? LEN_W'(HEAP_UNITS - 1) : rd_data_reg[ENT_W-1:1];
    assign rd_used = ovr_reg ? 1'b0 : rd_data_reg[0];

    // Walk arithmetic
    assign follow_w    = WIDE_W'(cur_idx_reg) + WIDE_W'(cur_len_reg) + WIDE_W'(1);
    assign merged_w    = WIDE_W'(cur_len_reg) + WIDE_W'(rd_len) + WIDE_W'(1);
    assign split_idx_w = WIDE_W'(cur_idx_reg) + WIDE_W'(want_reg) + WIDE_W'(1);
    assign split_len_w = WIDE_W'(cur_len_reg) - WIDE_W'(want_reg) - WIDE_W'(1);

    // Request decode from the input channel
    assign in_unit    = s_payload.payload_offset[OFFSET_W-1:GRANULE_SHIFT];
    assign in_unit_m1 = WIDE_W'(in_unit) - WIDE_W'(1);
    assign in_want    = WANT_W'(s_payload.request_bytes[OFFSET_W-1:GRANULE_SHIFT])
                        + WANT_W'(1);

    assign out_free = !m_valid_reg || m_ready;

    // Status to controller
    always_comb begin
        sts.in_op      = s_payload.operation;
        sts.in_free_ok = (in_unit != '0) && (in_unit_m1 < WIDE_W'(HEAP_UNITS));
        sts.cur_used   = cur_used_reg;
        sts.nxt_in     = follow_w < WIDE_W'(HEAP_UNITS);
        sts.fits       = CMP_W'(cur_len_reg) >= CMP_W'(want_reg);
        sts.need_split = CMP_W'(want_reg) < CMP_W'(cur_len_reg);
        sts.rd_used    = rd_used;
        sts.out_free   = out_free;
    end

    // Read address select
    always_comb begin
        unique case (cmd.rd_sel)
            RD_FOLLOW: rd_addr = IDX_W'(follow_w);
            RD_UNIT:   rd_addr = IDX_W'(in_unit_m1);
            default:   rd_addr = '0;
        endcase
    end
    assign ovr_next = (rd_addr == '0) && !hdr0_valid_reg;

    // Write address and data select
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = cur_idx_reg;
        wr_data = '0;
        unique case (cmd.wr)
            WR_MERGE: wr_data = {LEN_W'(merged_w), 1'b0};
            WR_ALLOC: wr_data = {LEN_W'(want_reg), 1'b1};
            WR_SPLIT: begin
                wr_addr = IDX_W'(split_idx_w);
                wr_data = {LEN_W'(split_len_w), 1'b0};
            end
            WR_FREE: begin
                wr_addr = free_idx_reg;
                wr_data = {rd_len, 1'b0};
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            ovr_reg     <= ovr_next;
        end
    end

    // Header 0 valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr0_valid_reg <= 1'b0;
        end else if (wr_en && (wr_addr == '0)) begin
            hdr0_valid_reg <= 1'b1;
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            op_reg       <= s_payload.operation;
            want_reg     <= in_want;
            free_idx_reg <= IDX_W'(in_unit_m1);
        end
    end

    // Current header registers
    always_ff @(posedge aclk) begin
        unique case (cmd.upd)
            CUR_START: cur_idx_reg <= '0;
            CUR_LOAD: begin
                cur_len_reg  <= rd_len;
                cur_used_reg <= rd_used;
            end
            CUR_STEP: cur_idx_reg <= IDX_W'(follow_w);
            CUR_ADV: begin
                cur_idx_reg  <= IDX_W'(follow_w);
                cur_len_reg  <= rd_len;
                cur_used_reg <= rd_used;
            end
            CUR_MERGE: cur_len_reg <= LEN_W'(merged_w);
            default: ;
        endcase
    end

    // Result register
    assign ro_w = (RO_W'(cur_idx_reg) + RO_W'(1)) << GRANULE_SHIFT;
    always_comb begin
        m_payload_next.success       = cmd.out_ok;
        m_payload_next.result_offset = (cmd.out_ok && (op_reg == OP_ALLOC))
                                       ? ro_w[OFFSET_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Checks
    `FFHA_ASSERT_IMP(a_rd_wr_excl, cmd.rd_en, cmd.wr == WR_NONE, "read and write together")
    `FFHA_ASSERT_IMP(a_split_in_heap, cmd.wr == WR_SPLIT,
        split_idx_w < WIDE_W'(HEAP_UNITS), "split header beyond heap")
    `FFHA_ASSERT_IMP(a_load_free_slot, cmd.out_load, out_free, "result register overrun")

endmodule

@@ sv/ffha_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffha_ctrl
// Controller for the allocator: sequences the block walk, merges, split,
// free write-back and result hand-off.
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"

module ffha_ctrl import ffha_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ffha_sts_t sts,
    output ffha_cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LOAD_CUR = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_LOAD_NXT = 3'd3;
    localparam logic [2:0] S_SPLIT    = 3'd4;
    localparam logic [2:0] S_FREE_WB  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       done_ok_reg, done_ok_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        done_ok_next = done_ok_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    if (sts.in_op == OP_FREE) begin
                        if (sts.in_free_ok) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_UNIT;
                            state_next = S_FREE_WB;
                        end else begin
                            done_ok_next = 1'b0;
                            state_next   = S_DONE;
                        end
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_ZERO;
                        cmd.upd    = CUR_START;
                        state_next = S_LOAD_CUR;
                    end
                end
            end
            S_LOAD_CUR: begin
                cmd.upd    = CUR_LOAD;
                state_next = S_CHECK;
            end
            // Free block: absorb following free blocks before the fit test; used block: step on
            S_CHECK: begin
                priority if (!sts.cur_used && sts.nxt_in) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_FOLLOW;
                    state_next = S_LOAD_NXT;
                end else if (!sts.cur_used && sts.fits) begin
                    cmd.wr       = WR_ALLOC;
                    done_ok_next = 1'b1;
                    state_next   = sts.need_split ? S_SPLIT : S_DONE;
                end else if (sts.nxt_in) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_FOLLOW;
                    cmd.upd    = CUR_STEP;
                    state_next = S_LOAD_CUR;
                end else begin
                    done_ok_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            // Next header in hand: merge it, or fit test and move on
            S_LOAD_NXT: begin
                priority if (!sts.rd_used) begin
                    cmd.upd    = CUR_MERGE;
                    cmd.wr     = WR_MERGE;
                    state_next = S_CHECK;
                end else if (sts.fits) begin
                    cmd.wr       = WR_ALLOC;
                    done_ok_next = 1'b1;
                    state_next   = sts.need_split ? S_SPLIT : S_DONE;
                end else begin
                    cmd.upd    = CUR_ADV;
                    state_next = S_CHECK;
                end
            end
            S_SPLIT: begin
                cmd.wr     = WR_SPLIT;
                state_next = S_DONE;
            end
            S_FREE_WB: begin
                cmd.wr       = WR_FREE;
                done_ok_next = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = done_ok_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            done_ok_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            done_ok_reg <= done_ok_next;
        end
    end

    // Checks
    `FFHA_ASSERT_NXT(a_busy_after_take, s_valid && s_ready, !s_ready, "took two items")
    `FFHA_ASSERT_NXT(a_done_hands_off, (state_reg == S_DONE) && sts.out_free,
        state_reg == S_IDLE, "result not handed off")

endmodule

@@ sv/first_fit_heap_allocator.sv @@
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a heap of HEAP_UNITS granules with one-granule
// block headers; merges free runs while walking and splits the block taken.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | ffha_in_t  (operation, bytes, offset)
//  m_      | out       | m_valid / m_ready  | ffha_out_t (result_offset, success)
//
//  Free: header read, write-back, then hand-off; an ignored free goes straight to hand-off.
//  Allocate: walks from header 0, merging free runs, then marks the first block that fits
//  and splits off any remainder; one header read at a time from the store.
//  Reset: no clearing pass; header 0 reads as one free block until written.
//  A waiting result holds in the output register; the next item is taken
//  meanwhile and its result waits in the controller until the register frees.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ffha_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output ffha_out_t m_payload
);

    ffha_cmd_t cmd;
    ffha_sts_t sts;

    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffha_datapath #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ sim/first_fit_heap_allocator_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate and free items into the allocator through a queue-fed
// driver, predicts each result with a shadow copy of the block headers and
// checks every returned item in order against that prediction.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int unsigned HEAP_UNITS    = 4096;
    localparam int unsigned LEN_W         = 12;
    localparam int unsigned RANDOM_ITEMS  = 430;
    localparam int unsigned LIVE_CAP      = 40;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 64;
    localparam int unsigned IDLE_PERCENT  = 18;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             used;
    } header_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ffha_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ffha_out_t m_payload;

    // Shadow heap and bookkeeping
    header_t     heap_map [HEAP_UNITS];
    int unsigned live_offsets [$];
    ffha_in_t    pending_requests [$];
    ffha_out_t   expected_results [$];
    int unsigned issued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    first_fit_heap_allocator #(
        .HEAP_UNITS(HEAP_UNITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // No idling at all while this window of items goes through
    function automatic bit steady_window();
        return accepted_count >= 220 && accepted_count < 320;
    endfunction

    function automatic bit idle_roll();
        return !steady_window() && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Header that follows block g; HEAP_UNITS marks the end of the heap
    function automatic int unsigned next_header(int unsigned g);
        int unsigned n;
        n = g + 1 + heap_map[g].len;
        return (n >= HEAP_UNITS) ? HEAP_UNITS : n;
    endfunction

    // Fold every directly following free block into free block g
    function automatic void absorb_free_run(int unsigned g);
        int unsigned n;
        if (heap_map[g].used)
            return;
        n = next_header(g);
        while (n < HEAP_UNITS && !heap_map[n].used) begin
            heap_map[g].len = heap_map[g].len + heap_map[n].len + 1'b1;
            n = next_header(g);
        end
    endfunction

    // Apply one item to the shadow heap and return the result it should give
    function automatic ffha_out_t predict_heap_result(ffha_in_t req);
        ffha_out_t   res;
        int unsigned want;
        int unsigned g;
        int unsigned old_len;
        int unsigned unit;
        res = '0;
        if (req.operation == OP_ALLOC) begin
            want = 1 + req.request_bytes / GRANULE_BYTES;
            g = 0;
            absorb_free_run(g);
            while (heap_map[g].used || heap_map[g].len < want) begin
                g = next_header(g);
                if (g >= HEAP_UNITS)
                    return res;
                absorb_free_run(g);
            end
            old_len = heap_map[g].len;
            heap_map[g] = '{len: LEN_W'(want), used: 1'b1};
            if (want < old_len)
                heap_map[g + 1 + want] = '{len: LEN_W'(old_len - want - 1), used: 1'b0};
            res.result_offset = OFFSET_W'((g + 1) * GRANULE_BYTES);
            res.success = 1'b1;
            live_offsets.push_back(res.result_offset);
        end else begin
            unit = req.payload_offset / GRANULE_BYTES;
            if (unit != 0 && unit - 1 < HEAP_UNITS) begin
                heap_map[unit - 1].used = 1'b0;
                res.success = 1'b1;
                for (int i = 0; i < live_offsets.size(); i++) begin
                    if (live_offsets[i] == unit * GRANULE_BYTES) begin
                        live_offsets.delete(i);
                        break;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic queue_request(logic op, int unsigned bytes, int unsigned offset);
        ffha_in_t req;
        req.operation = op;
        req.request_bytes = OFFSET_W'(bytes);
        req.payload_offset = OFFSET_W'(offset);
        pending_requests.push_back(req);
        issued_count++;
    endtask

    // Input driver: predict on accept, then offer the next item or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_heap_result(s_payload));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && !idle_roll()) begin
                    s_payload <= pending_requests.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side ready, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && accepted_count >= 120) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_roll();
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        ffha_out_t want_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: offset %0d success %0b",
                         $time, m_payload.result_offset, m_payload.success);
                mismatch_count++;
            end else begin
                want_res = expected_results.pop_front();
                if (m_payload.result_offset !== want_res.result_offset) begin
                    $display("%0t result_offset mismatch: expected %0d actual %0d",
                             $time, want_res.result_offset, m_payload.result_offset);
                    mismatch_count++;
                end
                if (m_payload.success !== want_res.success) begin
                    $display("%0t success mismatch: expected %0b actual %0b",
                             $time, want_res.success, m_payload.success);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int unsigned pick;
        int unsigned slot;
        int unsigned bytes;
        int unsigned offset;

        for (int i = 0; i < HEAP_UNITS; i++)
            heap_map[i] = '0;
        heap_map[0].len = LEN_W'(HEAP_UNITS - 1);

        // Directed: whole heap, no fit, ignored and odd frees, merges, splits
        queue_request(OP_ALLOC, 32752, 0);      // exact fit of the whole heap
        queue_request(OP_ALLOC, 0, 32767);      // nothing left
        queue_request(OP_FREE, 0, 32767);       // mark cleared inside a payload
        queue_request(OP_FREE, 32767, 0);       // below first payload
        queue_request(OP_FREE, 0, 7);           // below first payload, unaligned
        queue_request(OP_FREE, 0, 13);          // unaligned free of header 0
        queue_request(OP_ALLOC, 32767, 0);      // larger than the heap
        queue_request(OP_ALLOC, 32744, 0);      // leaves a zero-payload block
        queue_request(OP_ALLOC, 0, 0);          // zero-payload block too small
        queue_request(OP_FREE, 0, 8);
        queue_request(OP_ALLOC, 0, 0);          // merges with the tail block
        queue_request(OP_ALLOC, 7, 0);
        queue_request(OP_ALLOC, 8, 0);
        queue_request(OP_ALLOC, 15, 0);
        queue_request(OP_FREE, 0, 8);
        queue_request(OP_FREE, 0, 24);
        queue_request(OP_ALLOC, 16, 0);         // exact fit after merging two
        queue_request(OP_FREE, 0, 40);
        queue_request(OP_ALLOC, 0, 0);          // split with empty remainder
        queue_request(OP_FREE, 0, 64);
        queue_request(OP_ALLOC, 32767, 32767);  // no fit, merges stay
        queue_request(OP_FREE, 32767, 32760);   // entry 4094, not a header
        queue_request(OP_FREE, 0, 8);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Random: mostly alloc/free of live blocks, some noise and misfits
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            while (pending_requests.size() >= 2)
                @(posedge aclk);
            pick = $urandom_range(99);
            if (live_offsets.size() != 0 && (pick < 38 || live_offsets.size() >= LIVE_CAP)) begin
                slot = $urandom_range(live_offsets.size() - 1);
                offset = live_offsets[slot];
                if ($urandom_range(3) == 0)
                    offset += $urandom_range(GRANULE_BYTES - 1);
                queue_request(OP_FREE, $urandom, offset);
            end else if (pick < 46) begin
                offset = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(32767);
                queue_request(OP_FREE, $urandom, offset);
            end else if (pick < 51) begin
                queue_request(OP_ALLOC, $urandom_range(32767), $urandom);
            end else begin
                pick = $urandom_range(99);
                if (pick < 75)
                    bytes = $urandom_range(255);
                else if (pick < 96)
                    bytes = $urandom_range(2047, 256);
                else
                    bytes = $urandom_range(8191, 2048);
                queue_request(OP_ALLOC, bytes, $urandom);
            end
        end

        while (accepted_count < issued_count)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASS first_fit_heap_allocator");
        else
            $display("FAIL first_fit_heap_allocator");
        $finish;
    end

    // Run limit
    initial begin
        #16ms;
        $display("FAIL first_fit_heap_allocator");
        $finish;
    end

endmodule

@@ first_fit_heap_allocator.f @@
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_datapath.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator.sv
sim/first_fit_heap_allocator_tb.sv
